// File: sv/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXT,
        PH_MASK,
        PH_DATA
    } phase_t;

    // WebSocket opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Result kinds
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_BINARY = 2'd1;
    localparam logic [1:0] KIND_PING   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Session status codes
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_CLOSE    = 2'd1;
    localparam logic [1:0] ST_PROTOCOL = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Length codes of the second header byte
    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [6:0] LEN7_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES  = 4'd2;
    localparam logic [3:0] EXT64_BYTES  = 4'd8;
    localparam logic [63:0] PING_MAX_LEN = 64'd125;

    localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;
    localparam int          QUEUE_DEPTH_DEFAULT = 4;

    // One result item on its way from the parser to the output
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       data_valid;
        logic       last;
        logic [1:0] status;
    } result_t;

endpackage

// File: sv/websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_tvalid / s_tready       s_tdata[7:0] = rx_byte
// m_axis    out  m_tvalid / m_tready       m_tdata = data, m_tlast = last,
//                                          m_tuser = kind, data_valid, status
// cfg       in   cfg_valid / cfg_ready     cfg_data = max_frame_bytes
//
// One byte is taken per cycle unless the queue is full; the parser decides its
// result in the same cycle and pushes it into a QUEUE_DEPTH-entry result queue.
// s_tready drops only while the result queue is full; m_tvalid shows a
// non-empty queue, so either side may stall on its own.
// Reset clears the parser, the session flag and the queue; max_frame_bytes
// returns to 65536. cfg_ready is always high.

module websocket_frame_deframer_unit
#(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] data
    output logic        m_tlast,
    output logic [4:0]  m_tuser,    // [1:0] kind, [2] data_valid, [4:3] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic             in_fire;
    logic             cfg_fire;
    logic             res_valid;
    wsd_pkg::result_t res;
    wsd_pkg::result_t head;
    logic             q_full;

    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Front: parse and classify each byte
    wsd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (s_tdata),
        .cfg_fire  (cfg_fire),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // Back: queue results toward the output stream
    wsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_tready),
        .full      (q_full),
        .not_empty (m_tvalid),
        .head      (head)
    );

    // Pack the queue head onto the output stream
    assign m_tdata = head.data;
    assign m_tlast = head.last;
    assign m_tuser = {head.status, head.data_valid, head.kind};

endmodule

// File: sv/wsd_parser.sv
`timescale 1ns / 1ps

module wsd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_fire,
    input  logic [31:0]         cfg_data,
    output logic                res_valid,
    output wsd_pkg::result_t    res
);

    wsd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [3:0]  ext_reg, ext_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  pos_reg, pos_next;
    logic        closed_reg, closed_next;
    logic [31:0] max_reg;

    logic        step;
    logic        hdr1_bad;
    logic [6:0]  len7;
    logic        len7_ext;
    logic [63:0] ext_len;
    logic        ext_done;
    logic        ext_big_bad;
    logic [63:0] chk_len;
    logic        too_long;
    logic        ping_big;
    logic        delivered;
    logic [1:0]  data_kind;
    logic [7:0]  key_byte;
    logic        final_byte;
    logic        mask_done;

    assign step        = in_fire && !closed_reg;
    assign hdr1_bad    = !rx_byte[7] || (rx_byte[6:4] != 3'd0);
    assign len7        = rx_byte[6:0];
    assign len7_ext    = (len7 == wsd_pkg::LEN7_EXT16) || (len7 == wsd_pkg::LEN7_EXT64);
    assign ext_len     = {len_reg[55:0], rx_byte};
    assign ext_done    = (ext_reg <= 4'd1);
    assign ext_big_bad = (ext_reg == wsd_pkg::EXT64_BYTES) && rx_byte[7];
    assign chk_len     = (phase_reg == wsd_pkg::PH_HDR2) ? {57'd0, len7} : ext_len;
    assign too_long    = chk_len > {32'd0, max_reg};
    assign ping_big    = (opcode_reg == wsd_pkg::OP_PING) && (chk_len > wsd_pkg::PING_MAX_LEN);
    assign final_byte  = (len_reg == 64'd1);
    assign mask_done   = (pos_reg == 2'd3);

    // Classify the frame opcode
    always_comb
    begin
        delivered = opcode_reg inside {wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY, wsd_pkg::OP_PING};
        if (opcode_reg == wsd_pkg::OP_TEXT)
            data_kind = wsd_pkg::KIND_TEXT;
        else if (opcode_reg == wsd_pkg::OP_BINARY)
            data_kind = wsd_pkg::KIND_BINARY;
        else
            data_kind = wsd_pkg::KIND_PING;
    end

    // Select the mask byte for this payload position
    always_comb
    begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                wsd_pkg::PH_HDR1:
                    phase_next = hdr1_bad ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_HDR2;
                wsd_pkg::PH_HDR2:
                begin
                    if (!rx_byte[7])
                        phase_next = wsd_pkg::PH_HDR1;
                    else if (len7_ext)
                        phase_next = wsd_pkg::PH_EXT;
                    else if (too_long)
                        phase_next = wsd_pkg::PH_HDR1;
                    else
                        phase_next = wsd_pkg::PH_MASK;
                end
                wsd_pkg::PH_EXT:
                begin
                    if (ext_big_bad)
                        phase_next = wsd_pkg::PH_HDR1;
                    else if (!ext_done)
                        phase_next = wsd_pkg::PH_EXT;
                    else if (too_long)
                        phase_next = wsd_pkg::PH_HDR1;
                    else
                        phase_next = wsd_pkg::PH_MASK;
                end
                wsd_pkg::PH_MASK:
                begin
                    if (mask_done)
                        phase_next = (len_reg == 64'd0) ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_DATA;
                end
                wsd_pkg::PH_DATA:
                    phase_next = final_byte ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_DATA;
                default:
                    phase_next = wsd_pkg::PH_HDR1;
            endcase
        end
    end

    // Datapath updates and result generation
    always_comb
    begin
        opcode_next = opcode_reg;
        ext_next    = ext_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        closed_next = closed_reg;
        res_valid   = 1'b0;
        res         = '{kind: wsd_pkg::KIND_NONE, data: 8'd0, data_valid: 1'b0,
                        last: 1'b0, status: wsd_pkg::ST_RUNNING};
        if (step)
        begin
            case (phase_reg)
                wsd_pkg::PH_HDR1:
                begin
                    if (hdr1_bad)
                    begin
                        closed_next = 1'b1;
                        res_valid   = 1'b1;
                        res.status  = wsd_pkg::ST_PROTOCOL;
                    end
                    else
                        opcode_next = rx_byte[3:0];
                end
                wsd_pkg::PH_HDR2:
                begin
                    if (!rx_byte[7])
                    begin
                        closed_next = 1'b1;
                        res_valid   = 1'b1;
                        res.status  = wsd_pkg::ST_PROTOCOL;
                    end
                    else if (len7_ext)
                    begin
                        len_next = 64'd0;
                        ext_next = (len7 == wsd_pkg::LEN7_EXT64) ? wsd_pkg::EXT64_BYTES
                                                                  : wsd_pkg::EXT16_BYTES;
                    end
                    else
                    begin
                        len_next = chk_len;
                        if (too_long)
                        begin
                            closed_next = 1'b1;
                            res_valid   = 1'b1;
                            res.status  = wsd_pkg::ST_TOO_LONG;
                        end
                        else
                        begin
                            if (ping_big)
                                opcode_next = wsd_pkg::OP_PONG;
                            pos_next = 2'd0;
                            key_next = 32'd0;
                        end
                    end
                end
                wsd_pkg::PH_EXT:
                begin
                    if (ext_big_bad)
                    begin
                        closed_next = 1'b1;
                        res_valid   = 1'b1;
                        res.status  = wsd_pkg::ST_PROTOCOL;
                    end
                    else
                    begin
                        len_next = ext_len;
                        ext_next = (ext_reg != 4'd0) ? ext_reg - 4'd1 : 4'd0;
                        if (ext_done)
                        begin
                            if (too_long)
                            begin
                                closed_next = 1'b1;
                                res_valid   = 1'b1;
                                res.status  = wsd_pkg::ST_TOO_LONG;
                            end
                            else
                            begin
                                if (ping_big)
                                    opcode_next = wsd_pkg::OP_PONG;
                                pos_next = 2'd0;
                                key_next = 32'd0;
                            end
                        end
                    end
                end
                wsd_pkg::PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    pos_next = pos_reg + 2'd1;
                    // Empty frame ends as soon as the key is complete
                    if (mask_done && (len_reg == 64'd0))
                    begin
                        if (delivered)
                        begin
                            res_valid = 1'b1;
                            res.kind  = data_kind;
                            res.last  = 1'b1;
                        end
                        else if (opcode_reg != wsd_pkg::OP_PONG)
                        begin
                            closed_next = 1'b1;
                            res_valid   = 1'b1;
                            res.status  = (opcode_reg == wsd_pkg::OP_CLOSE) ? wsd_pkg::ST_CLOSE
                                                                            : wsd_pkg::ST_PROTOCOL;
                        end
                    end
                end
                wsd_pkg::PH_DATA:
                begin
                    pos_next = pos_reg + 2'd1;
                    len_next = len_reg - 64'd1;
                    if (delivered)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = data_kind;
                        res.data       = rx_byte ^ key_byte;
                        res.data_valid = 1'b1;
                        res.last       = final_byte;
                    end
                    else if (final_byte && (opcode_reg != wsd_pkg::OP_PONG))
                    begin
                        closed_next = 1'b1;
                        res_valid   = 1'b1;
                        res.status  = (opcode_reg == wsd_pkg::OP_CLOSE) ? wsd_pkg::ST_CLOSE
                                                                        : wsd_pkg::ST_PROTOCOL;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsd_pkg::PH_HDR1;
            opcode_reg <= 4'd0;
            ext_reg    <= 4'd0;
            len_reg    <= 64'd0;
            key_reg    <= 32'd0;
            pos_reg    <= 2'd0;
            closed_reg <= 1'b0;
            max_reg    <= wsd_pkg::MAX_FRAME_RESET;
        end
        else
        begin
            phase_reg  <= closed_next ? wsd_pkg::PH_HDR1 : phase_next;
            opcode_reg <= opcode_next;
            ext_reg    <= ext_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            closed_reg <= closed_next;
            if (cfg_fire)
                max_reg <= cfg_data;
        end
    end

    // A closed session stays closed and produces nothing
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("session reopened without reset");

    a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> !res_valid)
        else $error("result produced after session end");

    a_result_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_fire)
        else $error("result produced without an input transfer");

endmodule

// File: sv/wsd_queue.sv
`timescale 1ns / 1ps

module wsd_queue
#(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wsd_pkg::result_t    push_data,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output wsd_pkg::result_t    head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wsd_pkg::result_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue occupancy beyond depth");

    a_push_lost: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into a full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not follow a push");

endmodule

// File: sim/wsd_stream_checker.sv
`timescale 1ns / 1ps

// Watches the byte, result and limit channels of the deframer, keeps its own
// copy of the parser state and compares every result transfer in order.
module wsd_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [7:0] data
    input  logic        m_tlast,
    input  logic [4:0]  m_tuser,    // [1:0] kind, [2] data_valid, [4:3] status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          checked_count
);

    // Own copy of the parser state and the length limit
    wsd_pkg::phase_t parse_phase;
    logic [3:0]  frame_op;
    logic [3:0]  ext_left;
    logic [63:0] bytes_left;
    logic [31:0] mask_key;
    logic [1:0]  mask_pos;
    logic        closed;
    logic [31:0] max_len;

    wsd_pkg::result_t expected_results[$];
    int      mismatches;
    int      results_seen;

    function automatic wsd_pkg::result_t make_result(input logic [1:0] kind,
                                                     input logic [7:0] data,
                                                     input logic valid, input logic last,
                                                     input logic [1:0] status);
        wsd_pkg::result_t r;
        r.kind       = kind;
        r.data       = data;
        r.data_valid = valid;
        r.last       = last;
        r.status     = status;
        return r;
    endfunction

    function automatic bit delivers_payload();
        return frame_op == wsd_pkg::OP_TEXT || frame_op == wsd_pkg::OP_BINARY ||
               frame_op == wsd_pkg::OP_PING;
    endfunction

    function automatic logic [1:0] payload_kind();
        if (frame_op == wsd_pkg::OP_TEXT)
            return wsd_pkg::KIND_TEXT;
        if (frame_op == wsd_pkg::OP_BINARY)
            return wsd_pkg::KIND_BINARY;
        return wsd_pkg::KIND_PING;
    endfunction

    // End the session: one marker result, then every later byte is ignored
    function automatic bit close_session(input logic [1:0] status,
                                         output wsd_pkg::result_t r);
        closed      = 1'b1;
        parse_phase = wsd_pkg::PH_HDR1;
        r           = make_result(wsd_pkg::KIND_NONE, 8'h00, 1'b0, 1'b0, status);
        return 1'b1;
    endfunction

    // End of a frame whose payload is not delivered
    function automatic bit end_quiet_frame(output wsd_pkg::result_t r);
        r = '0;
        if (frame_op == wsd_pkg::OP_PONG)
            return 1'b0;
        return close_session((frame_op == wsd_pkg::OP_CLOSE) ? wsd_pkg::ST_CLOSE
                                                             : wsd_pkg::ST_PROTOCOL, r);
    endfunction

    // Length is complete: apply the limit, demote a large ping, start the key
    function automatic bit length_done(output wsd_pkg::result_t r);
        r = '0;
        if (bytes_left > {32'h0, max_len})
            return close_session(wsd_pkg::ST_TOO_LONG, r);
        if (frame_op == wsd_pkg::OP_PING && bytes_left > wsd_pkg::PING_MAX_LEN)
            frame_op = wsd_pkg::OP_PONG;
        mask_key    = '0;
        mask_pos    = '0;
        parse_phase = wsd_pkg::PH_MASK;
        return 1'b0;
    endfunction

    // Advance the parser by one received byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output wsd_pkg::result_t r);
        logic [7:0] plain;
        bit         done;
        r = '0;
        if (closed)
            return 1'b0;
        case (parse_phase)
            wsd_pkg::PH_HDR1:
            begin
                if (!b[7] || b[6:4] != 3'b000)
                    return close_session(wsd_pkg::ST_PROTOCOL, r);
                frame_op    = b[3:0];
                parse_phase = wsd_pkg::PH_HDR2;
                return 1'b0;
            end
            wsd_pkg::PH_HDR2:
            begin
                if (!b[7])
                    return close_session(wsd_pkg::ST_PROTOCOL, r);
                bytes_left = '0;
                if (b[6:0] == wsd_pkg::LEN7_EXT16 || b[6:0] == wsd_pkg::LEN7_EXT64)
                begin
                    ext_left    = (b[6:0] == wsd_pkg::LEN7_EXT16) ? wsd_pkg::EXT16_BYTES
                                                                  : wsd_pkg::EXT64_BYTES;
                    parse_phase = wsd_pkg::PH_EXT;
                    return 1'b0;
                end
                bytes_left = {57'd0, b[6:0]};
                return length_done(r);
            end
            wsd_pkg::PH_EXT:
            begin
                // A 64-bit length must keep its top bit clear
                if (ext_left == wsd_pkg::EXT64_BYTES && b[7])
                    return close_session(wsd_pkg::ST_PROTOCOL, r);
                bytes_left = {bytes_left[55:0], b};
                if (ext_left != 4'd0)
                    ext_left = ext_left - 4'd1;
                if (ext_left != 4'd0)
                    return 1'b0;
                return length_done(r);
            end
            wsd_pkg::PH_MASK:
            begin
                done     = (mask_pos == 2'd3);
                mask_key = {mask_key[23:0], b};
                mask_pos = mask_pos + 2'd1;
                if (!done)
                    return 1'b0;
                if (bytes_left != 64'd0)
                begin
                    parse_phase = wsd_pkg::PH_DATA;
                    return 1'b0;
                end
                // Empty frame: delivered kinds get a bare last marker
                parse_phase = wsd_pkg::PH_HDR1;
                if (delivers_payload())
                begin
                    r = make_result(payload_kind(), 8'h00, 1'b0, 1'b1, wsd_pkg::ST_RUNNING);
                    return 1'b1;
                end
                return end_quiet_frame(r);
            end
            wsd_pkg::PH_DATA:
            begin
                plain      = b ^ mask_key[8 * (3 - int'(mask_pos)) +: 8];
                mask_pos   = mask_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                done       = (bytes_left == 64'd0);
                if (done)
                    parse_phase = wsd_pkg::PH_HDR1;
                if (delivers_payload())
                begin
                    r = make_result(payload_kind(), plain, 1'b1, done, wsd_pkg::ST_RUNNING);
                    return 1'b1;
                end
                if (!done)
                    return 1'b0;
                return end_quiet_frame(r);
            end
            default:
            begin
                parse_phase = wsd_pkg::PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endfunction

    // Compare result transfers first, then predict from the byte transfer
    always @(posedge clk or negedge rst_n)
    begin : watch
        wsd_pkg::result_t got;
        wsd_pkg::result_t want;
        wsd_pkg::result_t fresh;
        if (!rst_n)
        begin
            parse_phase  = wsd_pkg::PH_HDR1;
            frame_op     = '0;
            ext_left     = '0;
            bytes_left   = '0;
            mask_key     = '0;
            mask_pos     = '0;
            closed       = 1'b0;
            max_len      = wsd_pkg::MAX_FRAME_RESET;
            mismatches   = 0;
            results_seen = 0;
            expected_results.delete();
            fail_count    <= 0;
            pending       <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_len = cfg_data;

            if (m_tvalid && m_tready)
            begin
                got.kind       = m_tuser[1:0];
                got.data       = m_tdata;
                got.data_valid = m_tuser[2];
                got.last       = m_tlast;
                got.status     = m_tuser[4:3];
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $error("result with nothing expected: kind %0d data 0x%02h status %0d",
                           got.kind, got.data, got.status);
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("kind", 8'(want.kind), 8'(got.kind));
                    check_field("data", want.data, got.data);
                    check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
                    check_field("last", 8'(want.last), 8'(got.last));
                    check_field("status", 8'(want.status), 8'(got.status));
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (deframe_byte(s_tdata, fresh))
                    expected_results = {expected_results, fresh};
            end

            fail_count    <= mismatches;
            pending       <= expected_results.size();
            checked_count <= results_seen;
        end
    end

endmodule

// File: sim/tb_websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unit;

    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_LIMIT   = 5000;
    localparam logic [7:0] HIGH_BIT      = 8'h80;    // FIN, MASK and 64-bit length top

    typedef enum int {FORM_7BIT, FORM_16BIT, FORM_64BIT} len_form_t;
    typedef enum int {
        END_CLOSE, END_BAD_OPCODE, END_FIN_CLEAR, END_RSV_SET,
        END_MASK_CLEAR, END_LONG64, END_TOO_LONG
    } session_end_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [7:0] data
    logic        m_tlast;
    logic [4:0]  m_tuser;     // [1:0] kind, [2] data_valid, [4:3] status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    int          fail_count;
    int          pending;
    int          checked_count;

    logic [31:0] cur_limit = wsd_pkg::MAX_FRAME_RESET;
    bit          tx_gaps;
    int          burst_left;
    bit          hold_req;
    int          holds_done;
    int unsigned bytes_sent;
    int          frames_sent;
    int          limits_used;

    websocket_frame_deframer_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    wsd_stream_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte, hold it until the transfer, then maybe open a gap
    task automatic drive_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Pause the sender until every expected result has come, plus a margin
    task automatic wait_until_drained();
        int waited;
        s_tvalid <= 1'b0;
        @(posedge clk);
        for (waited = 0; pending != 0 && waited < DRAIN_LIMIT; waited++)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_limit = value;
        limits_used++;
    endtask

    // Short form where it fits, with non-minimal extended forms mixed in
    function automatic len_form_t pick_form(input logic [63:0] len);
        int unsigned r;
        r = $urandom_range(0, 5);
        if (len <= 64'd125)
            return (r < 4) ? FORM_7BIT : (r == 4) ? FORM_16BIT : FORM_64BIT;
        if (len <= 64'd65535)
            return (r < 3) ? FORM_16BIT : FORM_64BIT;
        return FORM_64BIT;
    endfunction

    task automatic send_header(input logic [7:0] first, input logic [63:0] len,
                               input len_form_t form);
        drive_byte(first);
        case (form)
            FORM_7BIT:
            begin
                drive_byte(HIGH_BIT | {1'b0, len[6:0]});
            end
            FORM_16BIT:
            begin
                drive_byte(HIGH_BIT | {1'b0, wsd_pkg::LEN7_EXT16});
                drive_byte(len[15:8]);
                drive_byte(len[7:0]);
            end
            default:
            begin
                drive_byte(HIGH_BIT | {1'b0, wsd_pkg::LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    drive_byte(len[8 * i +: 8]);
            end
        endcase
    endtask

    // Send a masked frame whose unmasked payload is body
    task automatic send_frame(input logic [3:0] op, input len_form_t form,
                              input logic [31:0] key, input logic [7:0] body[$]);
        send_header(HIGH_BIT | {4'h0, op}, 64'(body.size()), form);
        for (int i = 3; i >= 0; i--)
            drive_byte(key[8 * i +: 8]);
        foreach (body[i])
            drive_byte(body[i] ^ key[8 * (3 - i % 4) +: 8]);
        frames_sent++;
    endtask

    // Well-formed frame of a delivered kind or pong, length within the limit
    task automatic send_random_frame();
        logic [3:0]  op;
        logic [31:0] key;
        logic [7:0]  body[$];
        int unsigned len;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = wsd_pkg::OP_TEXT;
        else if (pick < 70)
            op = wsd_pkg::OP_BINARY;
        else if (pick < 88)
            op = wsd_pkg::OP_PING;
        else
            op = wsd_pkg::OP_PONG;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            len = 0;
        else if (pick < 85)
            len = $urandom_range(1, 12);
        else if (pick < 96)
            len = $urandom_range(13, 60);
        else
            len = $urandom_range(120, 135);
        if (len > cur_limit)
            len = cur_limit;
        pick = $urandom_range(0, 9);
        key = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
        repeat (len)
            body = {body, 8'($urandom())};
        send_frame(op, pick_form(64'(len)), key, body);
    endtask

    // Receiver: changing ready patterns, plus a long hold-off on request
    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                holds_done++;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            for (tick = 0; tick < span && !hold_req; tick++)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= (tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned  budget [6];
        int unsigned  phase_start;
        logic [7:0]   body[$];
        logic [3:0]   op;
        logic [63:0]  huge;
        session_end_t end_kind;
        budget      = '{180, 180, 60, 140, 180, 140};
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        cfg_valid   = 1'b0;
        cfg_data    = 32'h0;
        rst_n       = 1'b0;
        tx_gaps     = 1'b1;
        burst_left  = 0;
        hold_req    = 1'b0;
        holds_done  = 0;
        bytes_sent  = 0;
        frames_sent = 0;
        limits_used = 1;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty frames, byte extremes, every length form, ping limits
        send_frame(wsd_pkg::OP_TEXT, FORM_7BIT, 32'h0, body);
        body = '{8'h00, 8'hFF};
        send_frame(wsd_pkg::OP_BINARY, FORM_7BIT, 32'h0, body);
        body = '{8'h00, 8'hFF, 8'h5A};
        send_frame(wsd_pkg::OP_TEXT, FORM_16BIT, 32'hFFFF_FFFF, body);
        body = '{8'hC3};
        send_frame(wsd_pkg::OP_BINARY, FORM_64BIT, $urandom(), body);
        body.delete();
        send_frame(wsd_pkg::OP_PING, FORM_7BIT, $urandom(), body);
        body = '{8'h12, 8'h34};
        send_frame(wsd_pkg::OP_PONG, FORM_7BIT, $urandom(), body);
        body.delete();
        repeat (125)
            body = {body, 8'($urandom())};
        send_frame(wsd_pkg::OP_PING, FORM_7BIT, $urandom(), body);
        body = {body, 8'($urandom())};
        send_frame(wsd_pkg::OP_PING, FORM_16BIT, $urandom(), body);

        // Random frames under a series of length limits
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                wait_until_drained();
                case (p)
                    1:       write_limit(32'hFFFF_FFFF);
                    2:       write_limit(32'h0);
                    3:       write_limit($urandom_range(1, 8));
                    4:       write_limit($urandom_range(126, 5000));
                    default: write_limit($urandom());
                endcase
            end
            tx_gaps    = (p != 1) && ($urandom_range(0, 3) != 0);
            burst_left = 0;
            if (p == 0 || p == 3)
                hold_req = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < budget[p])
                send_random_frame();
        end

        // End the session one way, then show that later bytes are ignored
        end_kind = session_end_t'($urandom_range(0, 6));
        case (end_kind)
            END_CLOSE, END_BAD_OPCODE:
            begin
                if (end_kind == END_CLOSE)
                begin
                    op = wsd_pkg::OP_CLOSE;
                end
                else
                begin
                    do
                        op = 4'($urandom_range(0, 15));
                    while (op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BINARY ||
                           op == wsd_pkg::OP_CLOSE || op == wsd_pkg::OP_PING ||
                           op == wsd_pkg::OP_PONG);
                end
                body.delete();
                repeat ($urandom_range(0, 3))
                    if (body.size() < cur_limit)
                        body = {body, 8'($urandom())};
                send_frame(op, pick_form(64'(body.size())), $urandom(), body);
            end
            END_FIN_CLEAR:
            begin
                drive_byte({1'b0, 7'($urandom())});
            end
            END_RSV_SET:
            begin
                drive_byte(HIGH_BIT | {1'b0, 3'($urandom_range(1, 7)), 4'($urandom())});
            end
            END_MASK_CLEAR:
            begin
                drive_byte(HIGH_BIT | {4'h0, wsd_pkg::OP_TEXT});
                drive_byte({1'b0, 7'($urandom())});
            end
            END_LONG64:
            begin
                drive_byte(HIGH_BIT | {4'h0, wsd_pkg::OP_BINARY});
                drive_byte(HIGH_BIT | {1'b0, wsd_pkg::LEN7_EXT64});
                drive_byte(HIGH_BIT | 8'($urandom()));
            end
            default:
            begin
                if (cur_limit == 32'hFFFF_FFFF)
                    huge = {1'b0, 31'($urandom()), 32'($urandom())} | 64'h1_0000_0000;
                else
                    huge = 64'(cur_limit) + 64'd1;
                send_header(HIGH_BIT | {4'h0, wsd_pkg::OP_BINARY}, huge, pick_form(huge));
            end
        endcase
        repeat (20)
            drive_byte(8'($urandom()));

        wait_until_drained();
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        $display("Covered %0d bytes in %0d frames under %0d length limits, %0d results checked",
                 bytes_sent, frames_sent, limits_used, checked_count);
        $display("Receiver hold-offs: %0d; session ended by %s", holds_done, end_kind.name());
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Timeout: stimulus or results stalled");
        $display("TEST FAILED");
        $finish;
    end

endmodule
